// ===== src/rfm_pkg.sv =====
// shared types and constants of the reciprocal frequency meter
package rfm_pkg;

  localparam int unsigned CounterBitsDefault = 32;
  localparam int unsigned FracBitsDefault    = 8;

  localparam int unsigned CntFieldBits = 32;
  localparam int unsigned ClkBits      = 28;
  localparam int unsigned OutBits      = 48;

  localparam logic [ClkBits-1:0] ClkReset = 28'd84000000;

  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_CAPTURE = 2'd1;
  localparam logic [1:0] OP_GATE    = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  typedef struct packed {
    logic snap;
    logic delta;
    logic mul;
    logic step;
    logic load;
  } cmd_t;

endpackage

// ===== src/rfm_ctrl.sv =====
// gate sequencing and divider control of the frequency meter
module rfm_ctrl #(
  parameter int unsigned COUNTER_BITS = rfm_pkg::CounterBitsDefault,
  parameter int unsigned FRAC_BITS    = rfm_pkg::FracBitsDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic [1:0]    s_op_i,
  output logic          s_ready_o,
  input  logic          m_ready_i,
  output logic          m_valid_o,
  output rfm_pkg::cmd_t cmd_o
);
  import rfm_pkg::*;

  localparam int unsigned DivSteps = COUNTER_BITS + ClkBits + FRAC_BITS;
  localparam int unsigned CntW     = $clog2(DivSteps);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_LOAD
  } state_e;

  typedef enum logic [1:0] {
    PH_WAIT_FIRST,
    PH_HELD,
    PH_DONE
  } phase_e;

  state_e          state_q;
  phase_e          phase_q;
  logic            gate_done_q;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q;
  logic            accept;
  logic            out_free;

  assign s_ready_o = (state_q == ST_IDLE);
  assign accept    = s_valid_i && s_ready_o;
  assign out_free  = !out_valid_q || m_ready_i;
  assign m_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    cmd_o.snap  = accept && (s_op_i == OP_CAPTURE) && (phase_q == PH_WAIT_FIRST);
    cmd_o.delta = accept && (s_op_i == OP_CAPTURE) && (phase_q == PH_HELD) && gate_done_q;
    cmd_o.mul   = (state_q == ST_MUL);
    cmd_o.step  = (state_q == ST_DIV);
    cmd_o.load  = (state_q == ST_LOAD) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_WAIT_FIRST;
      gate_done_q <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (s_op_i)
              OP_START: begin
                phase_q     <= PH_WAIT_FIRST;
                gate_done_q <= 1'b0;
              end
              OP_GATE: begin
                if (phase_q != PH_DONE) begin
                  gate_done_q <= 1'b1;
                end
              end
              OP_CAPTURE: begin
                if (phase_q == PH_WAIT_FIRST) begin
                  phase_q <= PH_HELD;
                end else if (phase_q == PH_HELD && gate_done_q) begin
                  phase_q <= PH_DONE;
                  state_q <= ST_MUL;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_MUL: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(DivSteps - 1)) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/rfm_dp.sv =====
// snapshots, multiplier, bit-serial divider and result register of the meter
module rfm_dp #(
  parameter int unsigned COUNTER_BITS = rfm_pkg::CounterBitsDefault,
  parameter int unsigned FRAC_BITS    = rfm_pkg::FracBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rfm_pkg::ClkBits-1:0]          cfg_wdata_i,
  input  logic [rfm_pkg::CntFieldBits-1:0]     ref_ticks_i,
  input  logic [rfm_pkg::CntFieldBits-1:0]     signal_count_i,
  input  rfm_pkg::cmd_t                        cmd_i,
  output logic [rfm_pkg::OutBits-1:0]          frequency_q8_o,
  output logic [1:0]                           status_o
);
  import rfm_pkg::*;

  localparam int unsigned Cb = COUNTER_BITS;
  localparam int unsigned Pw = Cb + ClkBits;
  localparam int unsigned Dw = Pw + FRAC_BITS;

  logic [ClkBits-1:0] clk_hz_q;
  logic [Cb-1:0]      ref_start_q;
  logic [Cb-1:0]      sig_start_q;
  logic [Cb-1:0]      rd_q;
  logic [Cb-1:0]      sd_q;
  logic [Dw-1:0]      dividend_q;
  logic [Cb-1:0]      rem_q;
  logic [OutBits-1:0] quo_q;
  logic               sat_q;
  logic [OutBits-1:0] freq_q;
  logic [1:0]         status_q;

  logic [Cb-1:0]      ref_now;
  logic [Cb-1:0]      sig_now;
  logic [Pw-1:0]      product;
  logic [Cb:0]        rem_ext;
  logic [Cb:0]        rem_diff;
  logic               rem_ge;

  assign ref_now  = ref_ticks_i[Cb-1:0];
  assign sig_now  = signal_count_i[Cb-1:0];
  assign product  = Pw'(sd_q) * Pw'(clk_hz_q);
  assign rem_ext  = {rem_q, dividend_q[Dw-1]};
  assign rem_ge   = (rem_ext >= {1'b0, rd_q});
  assign rem_diff = rem_ext - {1'b0, rd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= ClkReset;
    end else if (cfg_we_i) begin
      clk_hz_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.snap) begin
      ref_start_q <= ref_now;
      sig_start_q <= sig_now;
    end
    if (cmd_i.delta) begin
      rd_q <= ref_now - ref_start_q;
      sd_q <= sig_now - sig_start_q;
    end
    if (cmd_i.mul) begin
      dividend_q <= Dw'(product) << FRAC_BITS;
      rem_q      <= '0;
      quo_q      <= '0;
      sat_q      <= 1'b0;
    end else if (cmd_i.step) begin
      dividend_q <= dividend_q << 1;
      rem_q      <= rem_ge ? rem_diff[Cb-1:0] : rem_ext[Cb-1:0];
      quo_q      <= {quo_q[OutBits-2:0], rem_ge};
      sat_q      <= sat_q | quo_q[OutBits-1];
    end
    if (cmd_i.load) begin
      if (rd_q == '0) begin
        freq_q   <= '0;
        status_q <= STATUS_ZERO;
      end else if (sat_q) begin
        freq_q   <= '1;
        status_q <= STATUS_SAT;
      end else begin
        freq_q   <= quo_q;
        status_q <= STATUS_OK;
      end
    end
  end

  assign frequency_q8_o = freq_q;
  assign status_o       = status_q;

endmodule

// ===== src/reciprocal_frequency_meter.sv =====
// top level of the equal-precision reciprocal frequency meter
// input stream: tuser carries the operation (start, edge capture, gate elapsed),
// tdata the reference tick count and signal edge count sampled at the edge.
// a start word clears the gate; the first capture takes the opening snapshot,
// a gate word arms the close and the next capture takes the closing snapshot.
// only that closing capture yields a result word on the output stream:
// tdata = frequency in 1/256 hz (floor, saturating), tuser = status
// (valid, zero reference interval, saturated).
// cfg_we_i / cfg_wdata_i write the reference clock in hz (reset 84 MHz).
// words that give no result leave the meter idle and ready for the next. a closing
// capture passes through a multiply step, then the restoring divider that retires
// one quotient bit per cycle, then the load into the output register; no input
// is taken during that time.
// the result sits in an output register, so words keep being accepted while
// it waits; a new closing capture stalls before loading until it is taken.
// reset clears the gate state, drops any pending result and restores the
// default reference clock.
module reciprocal_frequency_meter #(
  parameter int unsigned COUNTER_BITS = rfm_pkg::CounterBitsDefault,
  parameter int unsigned FRAC_BITS    = rfm_pkg::FracBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rfm_pkg::ClkBits-1:0]     cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [63:0]                     s_axis_tdata,  // ref_ticks, signal_count
  input  logic [1:0]                      s_axis_tuser,  // operation
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [47:0]                     m_axis_tdata,  // frequency_q8
  output logic [1:0]                      m_axis_tuser   // status
);
  import rfm_pkg::*;

  cmd_t cmd;

  rfm_ctrl #(
    .COUNTER_BITS(COUNTER_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_op_i   (s_axis_tuser),
    .s_ready_o(s_axis_tready),
    .m_ready_i(m_axis_tready),
    .m_valid_o(m_axis_tvalid),
    .cmd_o    (cmd)
  );

  rfm_dp #(
    .COUNTER_BITS(COUNTER_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .ref_ticks_i   (s_axis_tdata[CntFieldBits-1:0]),
    .signal_count_i(s_axis_tdata[2*CntFieldBits-1:CntFieldBits]),
    .cmd_i         (cmd),
    .frequency_q8_o(m_axis_tdata),
    .status_o      (m_axis_tuser)
  );

endmodule

// ===== bench/reciprocal_frequency_meter_tb.sv =====
// self-checking testbench for the reciprocal frequency meter with a built-in result predictor
module reciprocal_frequency_meter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfm_pkg::*;

  localparam int unsigned Frac        = FracBitsDefault;
  localparam int unsigned DrainCycles = 100;
  localparam logic [ClkBits-1:0] ClkMax  = '1;
  localparam logic [ClkBits-1:0] ClkFast = 28'd200_000_000;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef enum logic [1:0] {
    WAIT_OPEN,
    HOLD_OPEN,
    CLOSED
  } meas_phase_e;

  typedef struct packed {
    logic [OutBits-1:0] freq_q8;
    logic [1:0]         status;
  } freq_result_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [ClkBits-1:0] cfg_wdata_i   = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [63:0]        s_axis_tdata  = '0;  // ref_ticks, signal_count
  logic [1:0]         s_axis_tuser  = '0;  // operation
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [47:0]        m_axis_tdata;        // frequency_q8
  logic [1:0]         m_axis_tuser;        // status

  // predictor state
  logic [ClkBits-1:0] ref_clock_hz   = ClkReset;
  meas_phase_e        meas_phase     = WAIT_OPEN;
  logic               gate_armed     = 1'b0;
  logic [31:0]        open_ref_ticks = '0;
  logic [31:0]        open_sig_count = '0;

  freq_result_t freq_pending_q[$];

  int unsigned words_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned zero_seen    = 0;
  int unsigned sat_seen     = 0;
  int unsigned mismatches   = 0;
  int unsigned clock_writes = 0;
  bit          steady_flow  = 1'b0;

  reciprocal_frequency_meter u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic freq_result_t reciprocal_freq(input logic [31:0] ref_delta,
                                                   input logic [31:0] sig_delta,
                                                   input logic [ClkBits-1:0] clk_hz);
    logic [59:0]      scaled;
    logic [59+Frac:0] quot;
    freq_result_t     res;
    scaled = 60'(sig_delta) * 60'(clk_hz);
    if (ref_delta == '0) begin
      res.freq_q8 = '0;
      res.status  = STATUS_ZERO;
    end else begin
      quot = {scaled, {Frac{1'b0}}} / (60 + Frac)'(ref_delta);
      if (quot[59+Frac:OutBits] != '0) begin
        res.freq_q8 = '1;
        res.status  = STATUS_SAT;
      end else begin
        res.freq_q8 = quot[OutBits-1:0];
        res.status  = STATUS_OK;
      end
    end
    return res;
  endfunction

  function automatic void meter_accept(input logic [1:0] op, input logic [31:0] ticks,
                                       input logic [31:0] count);
    logic [31:0] ref_delta;
    logic [31:0] sig_delta;
    ref_delta = ticks - open_ref_ticks;
    sig_delta = count - open_sig_count;
    case (op)
      OP_START: begin
        meas_phase = WAIT_OPEN;
        gate_armed = 1'b0;
      end
      OP_GATE: begin
        if (meas_phase != CLOSED) gate_armed = 1'b1;
      end
      OP_CAPTURE: begin
        if (meas_phase == WAIT_OPEN) begin
          open_ref_ticks = ticks;
          open_sig_count = count;
          meas_phase     = HOLD_OPEN;
        end else if (meas_phase == HOLD_OPEN && gate_armed) begin
          freq_pending_q.push_back(reciprocal_freq(ref_delta, sig_delta, ref_clock_hz));
          meas_phase = CLOSED;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [31:0] ticks,
                           input logic [31:0] count);
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (!steady_flow && $urandom_range(0, 99) < 11) idle_cycles++;
    if (idle_cycles != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle_cycles) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {count, ticks};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    meter_accept(op, ticks, count);
    words_sent++;
  endtask

  task automatic drain_meter();
    s_axis_tvalid <= 1'b0;
    while (freq_pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_ref_clock(input logic [ClkBits-1:0] hz);
    drain_meter();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= hz;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    ref_clock_hz = hz;
    clock_writes++;
  endtask

  task automatic measure_once(input logic [31:0] t0, input logic [31:0] c0,
                              input logic [31:0] ref_delta, input logic [31:0] sig_delta);
    send_word(OP_START, $urandom, $urandom);
    send_word(OP_CAPTURE, t0, c0);
    send_word(OP_GATE, $urandom, $urandom);
    send_word(OP_CAPTURE, t0 + ref_delta, c0 + sig_delta);
  endtask

  function automatic logic [31:0] pick_delta();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 255);
      3: return $urandom_range(1, 1_000_000);
      4: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // straight from reset with no start word; both counters wrap
  task automatic test_basic_measure();
    send_word(OP_CAPTURE, 32'hFFFF_FF00, 32'hFFFF_FFFF);
    send_word(OP_GATE, 32'h0, 32'h0);
    send_word(OP_CAPTURE, 32'hFFFF_FF00 + 32'd84_000_000, 32'd999);
  endtask

  task automatic test_gate_before_edge();
    send_word(OP_START, 32'h0, 32'h0);
    send_word(OP_GATE, 32'h1234_5678, 32'h8765_4321);
    send_word(OP_CAPTURE, 32'd1000, 32'd10);
    send_word(OP_CAPTURE, 32'd1000 + 32'd84_000, 32'd10 + 32'd4321);
  endtask

  task automatic test_ignored_words();
    send_word(OP_START, 32'h0, 32'h0);
    send_word(OP_CAPTURE, 32'd500, 32'd7);
    send_word(OP_CAPTURE, 32'd900, 32'd9);
    send_word(OP_GATE, 32'h0, 32'h0);
    send_word(OP_GATE, 32'h0, 32'h0);
    send_word(OpUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_CAPTURE, 32'd500 + 32'd21_000_000, 32'd7 + 32'd77);
    send_word(OP_CAPTURE, 32'd3, 32'd4);
    send_word(OP_GATE, 32'd5, 32'd6);
  endtask

  task automatic test_zero_and_saturation();
    measure_once(32'hDEAD_BEEF, 32'h0000_0001, 32'h0, 32'd12345);
    measure_once(32'h0, 32'h0, 32'h1, 32'hFFFF_FFFF);
  endtask

  task automatic test_clock_register();
    logic [ClkBits-1:0] hz_list[4];
    hz_list = '{28'd0, 28'd1, ClkMax, ClkFast};
    foreach (hz_list[i]) begin
      write_ref_clock(hz_list[i]);
      measure_once($urandom, $urandom, $urandom_range(1, 1 << 20), $urandom_range(0, 1 << 20));
    end
  endtask

  task automatic random_measurement();
    logic [31:0] t0;
    logic [31:0] c0;
    logic [31:0] ref_delta;
    logic [31:0] sig_delta;
    int          kind;
    t0        = $urandom;
    c0        = $urandom;
    ref_delta = pick_delta();
    sig_delta = pick_delta();
    kind      = $urandom_range(0, 9);
    if (kind < 6) begin
      send_word(OP_START, $urandom, $urandom);
      send_word(OP_CAPTURE, t0, c0);
      repeat ($urandom_range(0, 1)) send_word(OP_CAPTURE, $urandom, $urandom);
      repeat ($urandom_range(1, 2)) send_word(OP_GATE, $urandom, $urandom);
      send_word(OP_CAPTURE, t0 + ref_delta, c0 + sig_delta);
    end else if (kind < 8) begin
      send_word(OP_START, $urandom, $urandom);
      send_word(OP_GATE, $urandom, $urandom);
      send_word(OP_CAPTURE, t0, c0);
      send_word(OP_CAPTURE, t0 + ref_delta, c0 + sig_delta);
    end else begin
      repeat ($urandom_range(1, 4)) send_word(2'($urandom_range(0, 3)), $urandom, $urandom);
    end
  endtask

  task automatic test_random_measurements();
    logic [ClkBits-1:0] hz;
    int unsigned        phase_end;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1:       hz = ClkFast;
        3:       hz = ClkReset;
        default: hz = ClkBits'($urandom_range(1, 200_000_000));
      endcase
      steady_flow = (ph == 2);
      write_ref_clock(hz);
      phase_end = words_sent + 200;
      while (words_sent < phase_end) random_measurement();
    end
    steady_flow = 1'b0;
  endtask

  always @(posedge clk_i) m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 11);

  always @(posedge clk_i) begin : check_results
    freq_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (freq_pending_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word: freq %h status %0d",
                                m_axis_tdata, m_axis_tuser));
      end else begin
        want = freq_pending_q.pop_front();
        if (want.status == STATUS_ZERO) zero_seen++;
        if (want.status == STATUS_SAT) sat_seen++;
        if (m_axis_tdata !== want.freq_q8 || m_axis_tuser !== want.status) begin
          note_mismatch($sformatf("got freq %h status %0d, wanted freq %h status %0d",
                                  m_axis_tdata, m_axis_tuser, want.freq_q8, want.status));
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results still pending", freq_pending_q.size());
    $display("reciprocal_frequency_meter_tb NOT OK");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_measure();
    test_gate_before_edge();
    test_ignored_words();
    test_zero_and_saturation();
    test_clock_register();
    test_random_measurements();
    drain_meter();
    $display("covered %0d input words and %0d result words over %0d clock settings",
             words_sent, results_seen, clock_writes);
    $display("results with zero interval: %0d, saturated: %0d", zero_seen, sat_seen);
    if (mismatches == 0) begin
      $display("reciprocal_frequency_meter_tb OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("reciprocal_frequency_meter_tb NOT OK");
    end
    $finish;
  end

endmodule
